@@ hw/rtl/sresp_pkg.sv @@
// ----------------------------------------------------------------------------
// sresp_pkg
// Shared types, constants and elaboration-time helpers of the sensor response
// curve pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sresp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int LOG_FRAC      = 30;
	localparam int COEF_W        = 32;
	localparam int IDX_W         = 3;

	typedef enum logic [1:0] {
		MODE_LIN   = 2'd0,
		MODE_QUAD  = 2'd1,
		MODE_ROOT  = 2'd2,
		MODE_IDENT = 2'd3
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_MODE = 3'd0,
		REG_A    = 3'd1,
		REG_B    = 3'd2,
		REG_C    = 3'd3,
		REG_D    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		mode_t              mode;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [31:0] d;
	} cfg_t;

	// Per-transaction control that travels alongside the data.
	typedef struct packed {
		mode_t      mode;
		logic [7:0] x;
		logic       sat;
		logic       uneg;
		logic       zbase;
		logic       qneg;
	} side_t;

	// Integer square root, used only to build constant tables.
	function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] bits;
		n    = n_in;
		res  = 64'd0;
		bits = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (n >= res + bits) begin
				n   = n - (res + bits);
				res = (res >> 1) + bits;
			end else begin
				res = res >> 1;
			end
			bits = bits >> 2;
		end
		return res;
	endfunction

	// 2^(2^-(i+1)) with LOG_FRAC fraction bits, built by repeated square roots.
	function automatic logic [63:0] exp_const(input int i);
		logic [63:0] s;
		s = 64'd2 << LOG_FRAC;
		for (int j = 0; j <= i; j++) begin
			s = isqrt64(s << LOG_FRAC);
		end
		return s;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sresp_front.sv @@
// ----------------------------------------------------------------------------
// sresp_front
// Input stages: forms the curve operand, its magnitude, the square for the
// quadratic curve and the normalised mantissa for the logarithm.
// ----------------------------------------------------------------------------
`default_nettype none

module sresp_front #(
	parameter int FRAC_BITS = sresp_pkg::FRAC_BITS_DEF,
	parameter int MAG_W     = 32,
	parameter int NUM_W     = 64,
	parameter int P_W       = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [7:0]        response,
	input  wire sresp_pkg::cfg_t   cfg,
	output logic                   out_valid,
	output sresp_pkg::side_t       out_side,
	output logic [NUM_W-1:0]       out_num,
	output logic [30:0]            out_y,
	output logic [P_W-1:0]         out_p
);

	logic [MAG_W-1:0]      xf;
	logic signed [MAG_W:0] sq_v;
	logic signed [MAG_W:0] rt_v;
	logic signed [MAG_W:0] sel_v;
	logic [MAG_W-1:0]      mag;
	sresp_pkg::side_t      side;

	logic                  valid_s1;
	logic [MAG_W-1:0]      mag_s1;
	sresp_pkg::side_t      side_s1;

	logic [P_W-1:0]        msb;
	logic [P_W:0]          norm_sh;
	logic [MAG_W+30:0]     norm;

	assign xf    = MAG_W'(response) << FRAC_BITS;
	assign sq_v  = $signed({1'b0, xf}) + (MAG_W+1)'($signed(cfg.b));
	assign rt_v  = $signed({1'b0, xf}) + (MAG_W+1)'($signed(cfg.a));
	assign sel_v = (cfg.mode == sresp_pkg::MODE_ROOT) ? rt_v : sq_v;
	assign mag   = sel_v[MAG_W] ? MAG_W'(-sel_v) : sel_v[MAG_W-1:0];

	always_comb begin
		side       = '0;
		side.mode  = cfg.mode;
		side.x     = response;
		side.uneg  = sel_v[MAG_W];
		side.zbase = (mag == '0);
		case (cfg.mode)
			sresp_pkg::MODE_QUAD: side.sat = (cfg.a == 32'sd0);
			sresp_pkg::MODE_ROOT: side.sat = (cfg.b == 32'sd0) || ((mag == '0) && cfg.b[31]);
			default:              side.sat = 1'b0;
		endcase
	end

	always_comb begin
		msb = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (mag_s1[i]) begin
				msb = P_W'(i);
			end
		end
	end

	assign norm_sh = (P_W+1)'(MAG_W - 1) - {1'b0, msb};
	assign norm    = {mag_s1, 31'd0} << norm_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1   <= mag;
		side_s1  <= side;
		out_side <= side_s1;
		out_num  <= NUM_W'(mag_s1) * NUM_W'(mag_s1);
		out_y    <= norm[MAG_W+30 -: 31];
		out_p    <= msb;
	end

endmodule

`default_nettype wire

@@ hw/rtl/sresp_log.sv @@
// ----------------------------------------------------------------------------
// sresp_log
// Logarithm pipeline: one squaring step per stage, then a stage that builds
// the divider operands for either curve.
// ----------------------------------------------------------------------------
`default_nettype none

module sresp_log #(
	parameter int FRAC_BITS = sresp_pkg::FRAC_BITS_DEF,
	parameter int NUM_W     = 64,
	parameter int P_W       = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire sresp_pkg::side_t  in_side,
	input  wire logic [NUM_W-1:0]  in_num,
	input  wire logic [30:0]       in_y,
	input  wire logic [P_W-1:0]    in_p,
	input  wire sresp_pkg::cfg_t   cfg,
	output logic                   out_valid,
	output sresp_pkg::side_t       out_side,
	output logic [NUM_W-1:0]       out_num,
	output logic [31:0]            out_den
);

	localparam int LF = sresp_pkg::LOG_FRAC;

	typedef struct packed {
		sresp_pkg::side_t side;
		logic [30:0]      y;
		logic [LF-1:0]    frac;
		logic [P_W-1:0]   p;
		logic [NUM_W-1:0] num;
	} lstage_t;

	lstage_t st_s  [LF];
	logic    vld_s [LF];
	lstage_t head;

	always_comb begin
		head      = '0;
		head.side = in_side;
		head.y    = in_y;
		head.p    = in_p;
		head.num  = in_num;
	end

	for (genvar g = 0; g < LF; g++) begin : g_sq
		lstage_t     src;
		logic        src_v;
		lstage_t     nxt;
		logic [61:0] sq;

		if (g == 0) begin : g_first
			assign src   = head;
			assign src_v = in_valid;
		end else begin : g_next
			assign src   = st_s[g-1];
			assign src_v = vld_s[g-1];
		end

		always_comb begin
			nxt = src;
			sq  = {31'd0, src.y} * {31'd0, src.y};
			if (sq[61]) begin
				nxt.y               = sq[61:31];
				nxt.frac[LF-1-g]    = 1'b1;
			end else begin
				nxt.y = sq[60:30];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			st_s[g] <= nxt;
		end
	end

	// Operand build: log2 = (p - FRAC_BITS) + frac, scaled by 2^LOG_FRAC.
	lstage_t            tail;
	logic signed [7:0]  pf;
	logic [6:0]         pf_mag;
	logic [37:0]        l_mag;
	logic [31:0]        a_mag;
	logic [31:0]        b_mag;
	sresp_pkg::side_t   side_o;

	assign tail   = st_s[LF-1];
	assign pf     = $signed({1'b0, 7'(tail.p)}) - 8'sd0 - $signed(8'(FRAC_BITS));
	assign pf_mag = pf[7] ? 7'(-pf) : pf[6:0];
	assign l_mag  = pf[7] ? ({1'b0, pf_mag, 30'd0} - {8'd0, tail.frac})
	                      : ({1'b0, pf_mag, 30'd0} | {8'd0, tail.frac});
	assign a_mag  = cfg.a[31] ? (~cfg.a + 32'd1) : cfg.a;
	assign b_mag  = cfg.b[31] ? (~cfg.b + 32'd1) : cfg.b;

	always_comb begin
		side_o = tail.side;
		if (tail.side.mode == sresp_pkg::MODE_ROOT) begin
			side_o.qneg = pf[7] ^ cfg.b[31];
		end else begin
			side_o.qneg = cfg.a[31];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[LF-1];
		end
	end

	always_ff @(posedge clk) begin
		out_side <= side_o;
		if (tail.side.mode == sresp_pkg::MODE_ROOT) begin
			out_num <= NUM_W'(l_mag) << FRAC_BITS;
			out_den <= b_mag;
		end else begin
			out_num <= tail.num;
			out_den <= a_mag;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/sresp_div.sv @@
// ----------------------------------------------------------------------------
// sresp_div
// Pipelined restoring divider, two quotient bits per stage, shared by the
// quadratic quotient and the root exponent.
// ----------------------------------------------------------------------------
`default_nettype none

module sresp_div #(
	parameter int NUM_W = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire sresp_pkg::side_t  in_side,
	input  wire logic [NUM_W-1:0]  in_num,
	input  wire logic [31:0]       in_den,
	output logic                   out_valid,
	output sresp_pkg::side_t       out_side,
	output logic [NUM_W-1:0]       out_quo
);

	localparam int STAGES = NUM_W / 2;

	typedef struct packed {
		sresp_pkg::side_t side;
		logic [31:0]      rem;
		logic [31:0]      den;
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] quo;
	} dstage_t;

	dstage_t st_s  [STAGES];
	logic    vld_s [STAGES];
	dstage_t head;

	always_comb begin
		head      = '0;
		head.side = in_side;
		head.den  = in_den;
		head.num  = in_num;
	end

	for (genvar g = 0; g < STAGES; g++) begin : g_step
		dstage_t     src;
		logic        src_v;
		dstage_t     nxt;
		logic [32:0] r1;
		logic [32:0] r2;
		logic        q1;
		logic        q2;

		if (g == 0) begin : g_first
			assign src   = head;
			assign src_v = in_valid;
		end else begin : g_next
			assign src   = st_s[g-1];
			assign src_v = vld_s[g-1];
		end

		always_comb begin
			nxt = src;
			r1  = {src.rem, src.num[NUM_W-1]};
			q1  = (r1 >= {1'b0, src.den});
			if (q1) begin
				r1 = r1 - {1'b0, src.den};
			end
			r2  = {r1[31:0], src.num[NUM_W-2]};
			q2  = (r2 >= {1'b0, src.den});
			if (q2) begin
				r2 = r2 - {1'b0, src.den};
			end
			nxt.rem = r2[31:0];
			nxt.num = src.num << 2;
			nxt.quo = {src.quo[NUM_W-3:0], q1, q2};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			st_s[g] <= nxt;
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign out_side  = st_s[STAGES-1].side;
	assign out_quo   = st_s[STAGES-1].quo;

endmodule

`default_nettype wire

@@ hw/rtl/sresp_exp.sv @@
// ----------------------------------------------------------------------------
// sresp_exp
// Power pipeline: splits the exponent, multiplies in one constant root of two
// per stage, then shifts the result into the output format.
// ----------------------------------------------------------------------------
`default_nettype none

module sresp_exp #(
	parameter int FRAC_BITS = sresp_pkg::FRAC_BITS_DEF,
	parameter int NUM_W     = 64,
	parameter int POW_W     = 49
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire sresp_pkg::side_t  in_side,
	input  wire logic [NUM_W-1:0]  in_quo,
	output logic                   out_valid,
	output sresp_pkg::side_t       out_side,
	output logic [POW_W-1:0]       out_pow,
	output logic [62:0]            out_qcap
);

	localparam int LF = sresp_pkg::LOG_FRAC;

	typedef struct packed {
		sresp_pkg::side_t  side;
		logic [LF-1:0]     f;
		logic signed [8:0] sh;
		logic              cap;
		logic              zero;
		logic [62:0]       qcap;
		logic [30:0]       r;
	} estage_t;

	// Exponent split.
	logic [NUM_W:0]    kraw;
	logic [6:0]        kc;
	logic signed [8:0] sh;
	estage_t           head;
	logic              head_v;

	assign kraw = in_side.qneg ? (({1'b0, in_quo} + (NUM_W+1)'({LF{1'b1}})) >> LF)
	                           : ({1'b0, in_quo} >> LF);
	assign kc   = (kraw > (NUM_W+1)'(100)) ? 7'd100 : kraw[6:0];
	assign sh   = in_side.qneg ? (9'(FRAC_BITS - LF) - $signed({2'b0, kc}))
	                           : (9'(FRAC_BITS - LF) + $signed({2'b0, kc}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v <= 1'b0;
		end else begin
			head_v <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		head.side <= in_side;
		head.f    <= in_side.qneg ? LF'(-in_quo[LF-1:0]) : in_quo[LF-1:0];
		head.sh   <= sh;
		head.cap  <= !in_side.qneg && (kraw >= (NUM_W+1)'(33));
		head.zero <= (sh <= -9'sd64);
		head.qcap <= (in_quo > (NUM_W'(1) << 62)) ? (63'd1 << 62) : in_quo[62:0];
		head.r    <= 31'd1 << LF;
	end

	estage_t st_s  [LF];
	logic    vld_s [LF];

	for (genvar g = 0; g < LF; g++) begin : g_mul
		localparam logic [30:0] ROOT_K = 31'(sresp_pkg::exp_const(g));
		estage_t     src;
		logic        src_v;
		estage_t     nxt;
		logic [61:0] prod;

		if (g == 0) begin : g_first
			assign src   = head;
			assign src_v = head_v;
		end else begin : g_next
			assign src   = st_s[g-1];
			assign src_v = vld_s[g-1];
		end

		always_comb begin
			nxt  = src;
			prod = {31'd0, src.r} * {31'd0, ROOT_K};
			if (src.f[LF-1-g]) begin
				nxt.r = prod[60:30];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			st_s[g] <= nxt;
		end
	end

	// Scale into the output format and cap.
	estage_t           tail;
	logic [63:0]       wide;
	logic [63:0]       shifted;
	logic signed [8:0] shn;

	assign tail = st_s[LF-1];
	assign wide = {33'd0, tail.r};
	assign shn  = -tail.sh;

	always_comb begin
		if (tail.zero) begin
			shifted = 64'd0;
		end else if (!tail.sh[8]) begin
			shifted = wide << tail.sh[5:0];
		end else begin
			shifted = wide >> shn[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[LF-1];
		end
	end

	always_ff @(posedge clk) begin
		out_side <= tail.side;
		out_qcap <= tail.qcap;
		if (tail.cap || (shifted > 64'({POW_W{1'b1}}))) begin
			out_pow <= {POW_W{1'b1}};
		end else begin
			out_pow <= shifted[POW_W-1:0];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/sresp_back.sv @@
// ----------------------------------------------------------------------------
// sresp_back
// Output stages: coefficient scaling, curve selection, rounding half away
// from zero and clamping to the byte range.
// ----------------------------------------------------------------------------
`default_nettype none

module sresp_back #(
	parameter int FRAC_BITS = sresp_pkg::FRAC_BITS_DEF,
	parameter int POW_W     = 49
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire sresp_pkg::side_t  in_side,
	input  wire logic [POW_W-1:0]  in_pow,
	input  wire logic [62:0]       in_qcap,
	input  wire sresp_pkg::cfg_t   cfg,
	output logic                   done,
	output logic [7:0]             amplified,
	output logic                   clipped
);

	localparam int HI_W = 32 + POW_W - FRAC_BITS;
	localparam int LO_W = 32 + FRAC_BITS;

	logic [31:0]         mc;
	logic [HI_W-1:0]     hi_s1;
	logic [LO_W-1:0]     lo_s1;
	logic signed [40:0]  lin_s1;
	logic [62:0]         qcap_s1;
	sresp_pkg::side_t    side_s1;
	logic                valid_s1;

	logic [65:0]         sum;
	logic [62:0]         magr_s2;
	logic signed [41:0]  linv_s2;
	logic signed [64:0]  quadv_s2;
	logic signed [64:0]  qsigned;
	sresp_pkg::side_t    side_s2;
	logic                valid_s2;

	logic signed [65:0]  v;
	logic signed [65:0]  v_s3;
	sresp_pkg::side_t    side_s3;
	logic                valid_s3;

	logic [65:0]         absv;
	logic [65:0]         rm;

	assign mc = cfg.c[31] ? (~cfg.c + 32'd1) : cfg.c;

	always_ff @(posedge clk) begin
		hi_s1   <= HI_W'(mc) * HI_W'(in_pow[POW_W-1:FRAC_BITS]);
		lo_s1   <= LO_W'(mc) * LO_W'(in_pow[FRAC_BITS-1:0]);
		lin_s1  <= 41'($signed(cfg.a)) * 41'($signed({1'b0, in_side.x}));
		qcap_s1 <= in_qcap;
		side_s1 <= in_side;
	end

	assign sum     = 66'(hi_s1) + 66'(lo_s1 >> FRAC_BITS);
	assign qsigned = side_s1.qneg ? -$signed({2'b0, qcap_s1}) : $signed({2'b0, qcap_s1});

	always_ff @(posedge clk) begin
		magr_s2  <= (sum > (66'd1 << 62)) ? (63'd1 << 62) : sum[62:0];
		linv_s2  <= 42'(lin_s1) + 42'($signed(cfg.b));
		quadv_s2 <= qsigned + 65'($signed(cfg.c));
		side_s2  <= side_s1;
	end

	always_comb begin
		case (side_s2.mode)
			sresp_pkg::MODE_LIN:  v = 66'(linv_s2);
			sresp_pkg::MODE_QUAD: v = 66'(quadv_s2);
			sresp_pkg::MODE_ROOT: begin
				if (side_s2.zbase) begin
					v = 66'($signed(cfg.d));
				end else if (side_s2.uneg ^ cfg.c[31]) begin
					v = 66'($signed(cfg.d)) - $signed({3'b0, magr_s2});
				end else begin
					v = 66'($signed(cfg.d)) + $signed({3'b0, magr_s2});
				end
			end
			default: v = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		v_s3    <= v;
		side_s3 <= side_s2;
	end

	assign absv = v_s3[65] ? 66'(-v_s3) : 66'(v_s3);
	assign rm   = (absv + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done     <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (side_s3.mode == sresp_pkg::MODE_IDENT) begin
			amplified <= side_s3.x;
			clipped   <= 1'b0;
		end else if (side_s3.sat) begin
			amplified <= 8'hff;
			clipped   <= 1'b1;
		end else if (v_s3[65]) begin
			amplified <= 8'h00;
			clipped   <= (rm != '0);
		end else if (rm > 66'd255) begin
			amplified <= 8'hff;
			clipped   <= 1'b1;
		end else begin
			amplified <= rm[7:0];
			clipped   <= 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/sensor_response_curve.sv @@
// ----------------------------------------------------------------------------
// sensor_response_curve
// Shapes each 8-bit tactile sensor response through a configured linear,
// quadratic, signed root or identity curve, rounds and clamps it to a byte.
// ----------------------------------------------------------------------------
// The block takes one response per clock cycle for as long as start is held:
// busy stays low, so every transaction presented is taken. Each response
// produces exactly one result, shown on amplified and clipped for a single
// cycle while done is high; the receiver must take it then, since there is no
// way to hold it off. The block is a fixed-length pipeline, so results leave
// in the order responses arrived. Each response passes through the thirty
// logarithm squaring stages, the divider that retires two quotient bits per
// stage and the thirty power stages; the divider is shared by the quadratic
// quotient and the root exponent, so both curves take the same path.
//
// Coefficients are signed fixed point with FRAC_BITS fraction bits and are
// written through the plain write port: wr_idx 0 selects the curve mode,
// 1 to 4 the coefficients a to d; other indices are ignored. Writes should
// only be made while no transaction is in flight, because the front, the
// logarithm operand and the output stages read the live registers. A zero
// divisor, or a zero base raised to a negative exponent in root mode, reports 255 with clipped set.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_response_curve #(
	parameter int FRAC_BITS = sresp_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [7:0]                     response,
	output logic                                done,
	output logic [7:0]                          amplified,
	output logic                                clipped,
	input  wire logic                           wr_en,
	input  wire logic [sresp_pkg::IDX_W-1:0]    wr_idx,
	input  wire logic [sresp_pkg::COEF_W-1:0]   wr_data
);

	// Magnitude width of the shifted response plus a coefficient; the square
	// of that magnitude sets the divider width.
	localparam int MAG_W = ((FRAC_BITS + 8 > 31) ? (FRAC_BITS + 8) : 31) + 1;
	localparam int NUM_W = 2 * MAG_W;
	localparam int P_W   = $clog2(MAG_W);
	localparam int POW_W = 33 + FRAC_BITS;

	sresp_pkg::cfg_t cfg_q;

	// Configuration registers; a write is registered straight from the write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= sresp_pkg::MODE_IDENT;
			cfg_q.a    <= '0;
			cfg_q.b    <= '0;
			cfg_q.c    <= '0;
			cfg_q.d    <= '0;
		end else if (wr_en) begin
			case (sresp_pkg::reg_idx_t'(wr_idx))
				sresp_pkg::REG_MODE: cfg_q.mode <= sresp_pkg::mode_t'(wr_data[1:0]);
				sresp_pkg::REG_A:    cfg_q.a    <= wr_data;
				sresp_pkg::REG_B:    cfg_q.b    <= wr_data;
				sresp_pkg::REG_C:    cfg_q.c    <= wr_data;
				sresp_pkg::REG_D:    cfg_q.d    <= wr_data;
				default: ;
			endcase
		end
	end

	// The pipeline never stalls, so a new transaction is always welcome.
	assign busy = 1'b0;

	logic               fr_valid;
	sresp_pkg::side_t   fr_side;
	logic [NUM_W-1:0]   fr_num;
	logic [30:0]        fr_y;
	logic [P_W-1:0]     fr_p;

	logic               lg_valid;
	sresp_pkg::side_t   lg_side;
	logic [NUM_W-1:0]   lg_num;
	logic [31:0]        lg_den;

	logic               dv_valid;
	sresp_pkg::side_t   dv_side;
	logic [NUM_W-1:0]   dv_quo;

	logic               ex_valid;
	sresp_pkg::side_t   ex_side;
	logic [POW_W-1:0]   ex_pow;
	logic [62:0]        ex_qcap;

	// Operand forming, square and mantissa normalisation.
	sresp_front #(
		.FRAC_BITS (FRAC_BITS),
		.MAG_W     (MAG_W),
		.NUM_W     (NUM_W),
		.P_W       (P_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.response  (response),
		.cfg       (cfg_q),
		.out_valid (fr_valid),
		.out_side  (fr_side),
		.out_num   (fr_num),
		.out_y     (fr_y),
		.out_p     (fr_p)
	);

	// Logarithm of the root base, then selection of the divider operands.
	sresp_log #(
		.FRAC_BITS (FRAC_BITS),
		.NUM_W     (NUM_W),
		.P_W       (P_W)
	) u_log (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_side   (fr_side),
		.in_num    (fr_num),
		.in_y      (fr_y),
		.in_p      (fr_p),
		.cfg       (cfg_q),
		.out_valid (lg_valid),
		.out_side  (lg_side),
		.out_num   (lg_num),
		.out_den   (lg_den)
	);

	// Shared divider: quadratic quotient or root exponent.
	sresp_div #(
		.NUM_W     (NUM_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lg_valid),
		.in_side   (lg_side),
		.in_num    (lg_num),
		.in_den    (lg_den),
		.out_valid (dv_valid),
		.out_side  (dv_side),
		.out_quo   (dv_quo)
	);

	// Power of two of the exponent; the quadratic quotient is capped here.
	sresp_exp #(
		.FRAC_BITS (FRAC_BITS),
		.NUM_W     (NUM_W),
		.POW_W     (POW_W)
	) u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid),
		.in_side   (dv_side),
		.in_quo    (dv_quo),
		.out_valid (ex_valid),
		.out_side  (ex_side),
		.out_pow   (ex_pow),
		.out_qcap  (ex_qcap)
	);

	// Coefficient scaling, curve selection, rounding and clamping.
	sresp_back #(
		.FRAC_BITS (FRAC_BITS),
		.POW_W     (POW_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ex_valid),
		.in_side   (ex_side),
		.in_pow    (ex_pow),
		.in_qcap   (ex_qcap),
		.cfg       (cfg_q),
		.done      (done),
		.amplified (amplified),
		.clipped   (clipped)
	);

endmodule

`default_nettype wire
